>>> rtl/block_table_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef BLOCK_TABLE_ALLOCATOR_MACROS_SVH
`define BLOCK_TABLE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTA_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bta_pkg.sv
package bta_pkg;

  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned OFFSET_W = 13;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [BYTES_W-1:0]  request_bytes;
    logic [OFFSET_W-1:0] release_offset;
  } bta_req_t;

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] grant_offset;
  } bta_rsp_t;

  typedef struct packed {
    logic               done;
    logic [BYTES_W-1:0] quotient;
    logic               rem_nz;
  } bta_div_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN,
    ST_MARK,
    ST_SCALE,
    ST_FREE_READ,
    ST_FREE_LEN,
    ST_FREE_CLEAR,
    ST_FINISH
  } bta_state_t;

endpackage

>>> rtl/bta_divider.sv
module bta_divider import bta_pkg::*; #(
  parameter int unsigned DIVISOR = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BYTES_W-1:0] dividend,
  output bta_div_status_t    status
);

  // The quotient comes from a multiply by the rounded-up reciprocal of the divisor.
  // With SHIFT = BYTES_W + ceil(log2(DIVISOR)) it is exact for every dividend.
  localparam int unsigned SHIFT  = BYTES_W + $clog2(DIVISOR);
  localparam int unsigned MAG_W  = BYTES_W + 1;
  localparam int unsigned PROD_W = BYTES_W + MAG_W;
  localparam int unsigned BACK_W = BYTES_W + $clog2(DIVISOR + 1);
  localparam logic [MAG_W-1:0] MAGIC =
    MAG_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [BYTES_W-1:0] held;
  logic [BYTES_W-1:0] quo;
  logic [PROD_W-1:0]  prod;
  logic [BACK_W-1:0]  back;
  logic               mul_valid;
  logic               chk_valid;
  logic               rem_nz;
  logic               done;

  assign prod = PROD_W'(held) * PROD_W'(MAGIC);
  assign back = BACK_W'(quo) * BACK_W'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      mul_valid <= start;
      chk_valid <= mul_valid;
      done      <= chk_valid;
    end
  end

  // The quotient is registered first, then a check of whether anything is left over.
  always_ff @(posedge clk) begin
    if (start) begin
      held <= dividend;
    end
    if (mul_valid) begin
      quo <= BYTES_W'(prod >> SHIFT);
    end
    if (chk_valid) begin
      rem_nz <= (back != BACK_W'(held));
    end
  end

  assign status.done     = done;
  assign status.quotient = quo;
  assign status.rem_nz   = rem_nz;

endmodule

>>> rtl/block_table_allocator.sv
// First-fit allocator over a pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes each.
// Requests arrive on req (req_valid/req_stall) and every request answers with exactly
// one response on rsp (rsp_valid/rsp_stall): ok and, for a grant, the byte offset.
// The block table sits in one single-port-read, single-port-write memory, one entry
// per block, holding zero when free and the run length at the first block of a run.
// Allocate: the divider turns bytes into blocks, then the table is scanned at one table
// read per cycle, then one write per granted block, then the offset is scaled.
// Free: the divider turns the offset into a block index, the stored length is read,
// then one write per freed block. Clear: one zero write per table entry.
// One request is worked on at a time; req_stall is low only while the block is idle,
// and a finished response waits in the output register, so a new request can be taken
// while rsp_stall holds the previous response. A response that cannot be moved into
// the output register holds the sequencer until the receiver takes the old one.
// After reset the table is swept to zero, one entry per cycle, and req_stall stays high
// until the sweep is done.
`include "block_table_allocator_macros.svh"

module block_table_allocator import bta_pkg::*; #(
  parameter int unsigned NUM_BLOCKS  = 256,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  bta_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output bta_rsp_t rsp
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned MUL_W = IDX_W + $clog2(BLOCK_BYTES + 1);
  localparam logic [CNT_W-1:0] NB_C    = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(NUM_BLOCKS - 1);
  localparam logic [CNT_W:0]   NB_SUM  = (CNT_W + 1)'(NUM_BLOCKS);
  localparam logic [BYTES_W:0] NB_WIDE = (BYTES_W + 1)'(NUM_BLOCKS);

  bta_state_t state;
  bta_state_t state_next;

  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    end_ptr;
  logic [CNT_W-1:0]    run;
  logic [CNT_W-1:0]    need;
  logic [IDX_W-1:0]    start;
  logic [1:0]          kind_q;
  logic                clr_reply;
  logic                scan_valid;
  logic                res_ok;
  logic [OFFSET_W-1:0] res_off;

  logic [CNT_W-1:0] table_mem [NUM_BLOCKS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [CNT_W-1:0] mem_rdata;

  logic               div_start;
  logic [BYTES_W-1:0] div_dividend;
  bta_div_status_t    div_status;

  logic [BYTES_W-1:0] need_calc;
  logic               need_bad;
  logic               idx_bad;
  logic [CNT_W-1:0]   run_inc;
  logic               found;
  logic [CNT_W:0]     free_sum;
  logic [CNT_W-1:0]   free_end;
  logic [MUL_W-1:0]   scaled;
  logic               load;
  logic               rsp_take;

  bta_divider #(
    .DIVISOR(BLOCK_BYTES)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .status  (div_status)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= table_mem[mem_raddr];
  end

  assign need_calc = div_status.quotient + BYTES_W'(div_status.rem_nz);
  assign need_bad  = (need_calc == '0) || ({1'b0, need_calc} > NB_WIDE);
  assign idx_bad   = {1'b0, div_status.quotient} >= NB_WIDE;
  assign run_inc   = (mem_rdata == '0) ? run + 1'b1 : '0;
  assign found     = scan_valid && (run_inc == need);
  assign free_sum  = (CNT_W + 1)'(start) + (CNT_W + 1)'(mem_rdata);
  assign free_end  = (free_sum > NB_SUM) ? NB_C : CNT_W'(free_sum);
  assign scaled    = MUL_W'(start) * MUL_W'(BLOCK_BYTES);
  assign load      = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);
  assign rsp_take  = rsp_valid && !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (ptr == LAST_C) begin
          state_next = clr_reply ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.kind)
            KIND_ALLOC, KIND_FREE: state_next = ST_DIVIDE;
            KIND_CLEAR:            state_next = ST_CLEAR;
            default:               state_next = ST_FINISH;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_status.done) begin
          if (kind_q == KIND_ALLOC) begin
            state_next = need_bad ? ST_FINISH : ST_SCAN;
          end else begin
            state_next = idx_bad ? ST_FINISH : ST_FREE_READ;
          end
        end
      end
      ST_SCAN: begin
        priority if (found) begin
          state_next = ST_MARK;
        end else if (!scan_valid && ptr == NB_C) begin
          state_next = ST_FINISH;
        end
      end
      ST_MARK: begin
        if (ptr == end_ptr) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:     state_next = ST_FINISH;
      ST_FREE_READ: state_next = ST_FREE_LEN;
      ST_FREE_LEN:  state_next = ST_FREE_CLEAR;
      ST_FREE_CLEAR: begin
        if (ptr == end_ptr) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall    = (state != ST_IDLE);
    div_start    = 1'b0;
    div_dividend = req.request_bytes;
    mem_we       = 1'b0;
    mem_waddr    = ptr[IDX_W-1:0];
    mem_wdata    = '0;
    mem_raddr    = ptr[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        div_start = req_valid && (req.kind == KIND_ALLOC || req.kind == KIND_FREE);
        if (req.kind == KIND_FREE) begin
          div_dividend = BYTES_W'(req.release_offset);
        end
      end
      ST_CLEAR: mem_we = 1'b1;
      ST_MARK: begin
        mem_we    = (ptr != end_ptr);
        mem_wdata = (ptr == CNT_W'(start)) ? need : CNT_W'(1);
      end
      ST_FREE_READ:  mem_raddr = start;
      ST_FREE_CLEAR: mem_we = (ptr != end_ptr);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      ptr        <= '0;
      clr_reply  <= 1'b0;
      scan_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: ptr <= ptr + 1'b1;
        ST_IDLE: begin
          if (req_valid) begin
            ptr       <= '0;
            clr_reply <= (req.kind == KIND_CLEAR);
          end
        end
        ST_DIVIDE: begin
          ptr        <= '0;
          scan_valid <= 1'b0;
        end
        ST_SCAN: begin
          // The read data is registered and trails the address; a hit rewinds to the run start.
          scan_valid <= (ptr != NB_C);
          if (found) begin
            ptr <= ptr - need;
          end else if (ptr != NB_C) begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_MARK, ST_FREE_CLEAR: begin
          if (ptr != end_ptr) begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_FREE_LEN: ptr <= CNT_W'(start);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          kind_q  <= req.kind;
          res_ok  <= (req.kind == KIND_CLEAR);
          res_off <= '0;
        end
      end
      ST_DIVIDE: begin
        run <= '0;
        if (div_status.done) begin
          need   <= CNT_W'(need_calc);
          start  <= IDX_W'(div_status.quotient);
          res_ok <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_valid) begin
          run <= run_inc;
        end
        if (found) begin
          start   <= IDX_W'(ptr - need);
          end_ptr <= ptr;
        end
      end
      ST_FREE_LEN: begin
        end_ptr <= free_end;
        res_ok  <= 1'b1;
      end
      ST_SCALE: begin
        res_ok  <= 1'b1;
        res_off <= OFFSET_W'(scaled);
      end
      ST_FINISH: begin
        if (load) begin
          rsp.ok           <= res_ok;
          rsp.grant_offset <= res_off;
        end
      end
      default: ;
    endcase
  end

  `BTA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state != ST_IDLE, "accepted request did not start")
  `BTA_ASSERT_HOLDS(a_div_done_in_divide, div_status.done, state == ST_DIVIDE, "divider finished outside divide")
  `BTA_ASSERT_HOLDS(a_run_start_valid, state == ST_SCAN && found, need != '0 && ptr >= need, "found run starts before entry zero")
  `BTA_ASSERT_HOLDS(a_mark_inside_run, state == ST_MARK && mem_we, ptr < end_ptr && ptr >= CNT_W'(start), "mark write outside the found run")
  `BTA_ASSERT_HOLDS(a_rsp_from_finish, $rose(rsp_valid), $past(state) == ST_FINISH, "response raised outside finish")

endmodule

>>> sim/tb_block_table_allocator.sv
`timescale 1ns / 1ps

module tb_block_table_allocator;
  import bta_pkg::*;

  localparam int NUM_BLOCKS   = 256;
  localparam int BLOCK_BYTES  = 32;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_PRINTED  = 100;

  // The package names only the three live kinds; the fourth code must do nothing.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  bta_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  bta_rsp_t rsp;

  // While set, neither side inserts idle cycles or stalls.
  bit quiet = 1'b0;
  int unsigned idle_cycles = 0;

  block_table_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  class alloc_scoreboard;
    logic [8:0]  block_len [NUM_BLOCKS];
    bit          run_head [NUM_BLOCKS];
    bta_rsp_t    expected_grants [$];
    int unsigned mismatches, checked;
    int unsigned grants, refusals, frees, clears, unused;

    function new();
      wipe_table();
    endfunction

    function void wipe_table();
      foreach (block_len[i]) begin
        block_len[i] = '0;
        run_head[i] = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED)
        $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    // Applies one accepted request to the table copy and queues its response.
    function void note_request(bta_req_t r);
      bta_rsp_t want;
      int need, run, start, idx, stop;
      want = '0;
      case (r.kind)
        KIND_ALLOC: begin
          need = (int'(r.request_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
          run = 0;
          start = -1;
          if (need >= 1 && need <= NUM_BLOCKS) begin
            for (int i = 0; i < NUM_BLOCKS && start < 0; i++) begin
              run = (block_len[i] == 0) ? run + 1 : 0;
              if (run == need)
                start = i + 1 - need;
            end
          end
          if (start >= 0) begin
            for (int j = start; j < start + need; j++)
              block_len[j] = 9'd1;
            block_len[start] = 9'(need);
            run_head[start] = 1'b1;
            want.ok = 1'b1;
            want.grant_offset = OFFSET_W'(start * BLOCK_BYTES);
            grants++;
          end else begin
            refusals++;
          end
        end
        KIND_FREE: begin
          idx = int'(r.release_offset) / BLOCK_BYTES;
          frees++;
          if (idx < NUM_BLOCKS) begin
            stop = idx + int'(block_len[idx]);
            if (stop > NUM_BLOCKS)
              stop = NUM_BLOCKS;
            for (int j = idx; j < stop; j++) begin
              block_len[j] = '0;
              run_head[j] = 1'b0;
            end
            want.ok = 1'b1;
          end
        end
        KIND_CLEAR: begin
          wipe_table();
          want.ok = 1'b1;
          clears++;
        end
        default: begin
          unused++;
        end
      endcase
      expected_grants.push_back(want);
    endfunction

    task check_response(bta_rsp_t got);
      bta_rsp_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("response ok=%0b offset=%0d with no request outstanding",
                                  got.ok, got.grant_offset));
        return;
      end
      want = expected_grants.pop_front();
      checked++;
      if (got.ok !== want.ok)
        report_mismatch($sformatf("ok: got %0b, expected %0b", got.ok, want.ok));
      if (got.grant_offset !== want.grant_offset)
        report_mismatch($sformatf("grant_offset: got %0d, expected %0d",
                                  got.grant_offset, want.grant_offset));
    endtask

    // Returns the block index of a random live run start, or -1 if there is none.
    function int pick_run_head();
      int heads [$];
      foreach (run_head[i])
        if (run_head[i])
          heads.push_back(i);
      if (heads.size() == 0)
        return -1;
      return heads[$urandom_range(0, heads.size() - 1)];
    endfunction
  endclass

  alloc_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_response(rsp);
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 15);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bta_req_t make_req(logic [1:0] kind, logic [BYTES_W-1:0] bytes,
                                        logic [OFFSET_W-1:0] offset);
    bta_req_t r;
    r.kind = kind;
    r.request_bytes = bytes;
    r.release_offset = offset;
    return r;
  endfunction

  // Mostly allocations and frees of live runs, so the table fragments and refills.
  function automatic bta_req_t random_request();
    bta_req_t r;
    int roll, sel, head;
    r.request_bytes = BYTES_W'($urandom);
    r.release_offset = OFFSET_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      r.kind = KIND_ALLOC;
      sel = $urandom_range(0, 99);
      if (sel < 3)
        r.request_bytes = '0;
      else if (sel < 70)
        r.request_bytes = BYTES_W'($urandom_range(1, 256));
      else if (sel < 92)
        r.request_bytes = BYTES_W'($urandom_range(257, 2048));
      else
        r.request_bytes = BYTES_W'($urandom_range(2049, 65535));
    end else if (roll < 93) begin
      r.kind = KIND_FREE;
      head = sb.pick_run_head();
      if (head >= 0 && roll < 86)
        r.release_offset = OFFSET_W'(head * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
    end else if (roll < 97) begin
      r.kind = KIND_CLEAR;
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  task automatic send_request(input bta_req_t r);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  // Holds the request side off until every outstanding response has arrived.
  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_grants.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero size and oversize requests, then the whole pool as one run.
    send_request(make_req(KIND_ALLOC, 16'd0, 13'd0));
    send_request(make_req(KIND_ALLOC, 16'hFFFF, 13'd0));
    send_request(make_req(KIND_ALLOC, 16'(NUM_BLOCKS * BLOCK_BYTES), 13'd0));
    send_request(make_req(KIND_ALLOC, 16'd1, 13'd0));
    send_request(make_req(KIND_FREE, 16'hFFFF, 13'd0));
    // Freeing a block that is already free still succeeds.
    send_request(make_req(KIND_FREE, 16'd0, 13'd0));
    send_request(make_req(KIND_ALLOC, 16'd1, 13'd0));
    send_request(make_req(KIND_ALLOC, 16'd33, 13'd0));
    send_request(make_req(KIND_ALLOC, 16'd96, 13'd0));
    // Unaligned free of the two-block run, then first fit refills the hole.
    send_request(make_req(KIND_FREE, 16'd0, 13'd37));
    send_request(make_req(KIND_ALLOC, 16'd64, 13'd0));
    // Interior block of the three-block run: only that one entry is released.
    send_request(make_req(KIND_FREE, 16'd0, 13'd128));
    send_request(make_req(KIND_ALLOC, 16'd32, 13'd0));
    send_request(make_req(KIND_UNUSED, 16'hFFFF, 13'h1FFF));
    send_request(make_req(KIND_CLEAR, 16'hFFFF, 13'h1FFF));
    send_request(make_req(KIND_ALLOC, 16'((NUM_BLOCKS - 1) * BLOCK_BYTES), 13'd0));
    send_request(make_req(KIND_ALLOC, 16'd32, 13'd0));
    send_request(make_req(KIND_ALLOC, 16'd32, 13'd0));
    send_request(make_req(KIND_FREE, 16'd0, 13'h1FFF));
    send_request(make_req(KIND_ALLOC, 16'((NUM_BLOCKS - 1) * BLOCK_BYTES + 1), 13'd0));
    send_request(make_req(KIND_CLEAR, 16'd0, 13'd0));
    send_request(make_req(KIND_FREE, 16'd0, 13'h1FFF));
    drain_responses();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 400 && n < 550);
      if (n % 250 == 249)
        drain_responses();
      send_request(random_request());
    end
    quiet = 1'b0;
    drain_responses();
    repeat (600) @(posedge clk);

    if (sb.expected_grants.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.expected_grants.size()));
    $display("Sent %0d requests: %0d grants, %0d refused allocations, %0d frees, %0d clears, %0d unused kinds.",
             sb.grants + sb.refusals + sb.frees + sb.clears + sb.unused,
             sb.grants, sb.refusals, sb.frees, sb.clears, sb.unused);
    $display("Compared %0d responses with the predicted block table; %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
